[src/sio_pkg.sv]
// Types, constants and helper functions for the scan isolated outlier filter.
package sio_pkg;

  typedef enum logic [1:0] {
    KIND_FINITE  = 2'd0,
    KIND_POS_INF = 2'd1,
    KIND_NEG_INF = 2'd2,
    KIND_NAN     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_RANGE_MIN = 2'd1,
    CFG_RANGE_MAX = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_index_t;

  localparam int RANGE_W = 16;
  localparam int INTEN_W = 16;

  localparam logic [RANGE_W-1:0] THRESHOLD_RESET = 16'd100;
  localparam logic [RANGE_W-1:0] RANGE_MIN_RESET = 16'd0;
  localparam logic [RANGE_W-1:0] RANGE_MAX_RESET = 16'hFFFF;

  localparam int OUTQ_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    kind_t              kind;
    logic [INTEN_W-1:0] intensity;
    logic               rejected;
    logic               last;
  } result_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic differs(input logic [RANGE_W-1:0] c,
                                   input logic [RANGE_W-1:0] nr,
                                   input kind_t nk,
                                   input logic [RANGE_W-1:0] thr);
    logic [RANGE_W-1:0] d;
    logic               res;
    d = (c > nr) ? (c - nr) : (nr - c);
    case (nk) inside
      KIND_POS_INF, KIND_NEG_INF: res = 1'b1;
      KIND_NAN:                   res = 1'b0;
      default:                    res = (d > thr);
    endcase
    return res;
  endfunction

  function automatic result_t make_result(input logic [RANGE_W-1:0] r,
                                          input kind_t k,
                                          input logic [INTEN_W-1:0] inten,
                                          input logic rej,
                                          input logic last);
    result_t o;
    o.range_mm  = (k == KIND_FINITE) ? r : '0;
    o.kind      = k;
    o.intensity = inten;
    o.rejected  = rej;
    o.last      = last;
    return o;
  endfunction

endpackage

[src/sio_tap.sv]
// One window tap: holds a sample's range and kind, loaded from its upstream neighbour.
module sio_tap import sio_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic [RANGE_W-1:0] range_in,
  input  kind_t              kind_in,
  output logic [RANGE_W-1:0] range_q,
  output kind_t              kind_q
);

  always_ff @(posedge clk) begin
    if (load) begin
      range_q <= range_in;
      kind_q  <= kind_in;
    end
  end

endmodule

[src/sio_outq.sv]
// Result queue taking up to two results per cycle and handing out one per transfer.
module sio_outq import sio_pkg::*; #(
  parameter int DEPTH = OUTQ_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  result_t din0,
  input  result_t din1,
  input  logic    pop,
  output result_t dout,
  output logic    not_empty,
  output logic    room_for_two,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [1:0]         n_push;

  assign n_push     = {1'b0, push.first} + {1'b0, push.second};
  assign count_next = count + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= din0;
    end
    if (push.second) begin
      mem[wr_ptr + PTR_W'(1)] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  assign dout         = mem[rd_ptr];
  assign not_empty    = (count != '0);
  assign room_for_two = (count <= ROOM_LIMIT);
  assign level        = count;

endmodule

[src/scan_isolated_outlier_filter.sv]
// Top level of the scan isolated outlier filter: window taps, judgement and result queue.
//
// Accepts one lidar sample per clock while s_axis_tready is high. Each sample is judged
// once its next neighbour has arrived, so its result leaves one input later; the last
// sample of a scan releases two results in the same cycle, and a new first mark closes
// the held sample with one result. Results go through an OUTQ_DEPTH-entry queue (a
// power of two, at least two) that drains one per transfer: s_axis_tready is high while
// the queue has two free entries, so the input stalls only once the output has held off
// long enough for OUTQ_DEPTH-1 results to wait, and rises again after the transfer that
// brings the queue back to OUTQ_DEPTH-2. With the output always ready and OUTQ_DEPTH at
// least four the input never stalls. Configuration writes are taken in every cycle.
module scan_isolated_outlier_filter import sio_pkg::*; #(
  parameter int OUTQ_DEPTH = OUTQ_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // range_mm[15:0], intensity[31:16]
  input  logic [2:0]  s_axis_tuser,  // range_kind[1:0], first_of_scan[2]
  input  logic        s_axis_tlast,  // last_of_scan
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_range_mm[15:0], out_intensity[31:16]
  output logic [2:0]  m_axis_tuser,  // out_kind[1:0], rejected[2]
  output logic        m_axis_tlast,  // out_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [RANGE_W-1:0] threshold;
  logic [RANGE_W-1:0] valid_lo;
  logic [RANGE_W-1:0] valid_hi;

  logic               held_valid;
  logic               held_is_first;
  logic [INTEN_W-1:0] held_intensity;

  logic [RANGE_W-1:0] held_range;
  kind_t              held_kind;
  logic [RANGE_W-1:0] left_range;
  kind_t              left_kind;

  logic [RANGE_W-1:0] in_range;
  kind_t              in_kind;
  logic [INTEN_W-1:0] in_intensity;
  logic               in_first;
  logic               in_last;

  logic               accept;
  logic               flush_held;
  logic               judge_held;
  logic               rej;
  result_t            res_held;
  result_t            res_input;
  result_t            din0;
  push_t              push;
  logic               pop;
  result_t            dout;
  logic               q_not_empty;
  logic               q_room;
  logic [$clog2(OUTQ_DEPTH+1)-1:0] q_level;

  assign in_range     = s_axis_tdata[15:0];
  assign in_intensity = s_axis_tdata[31:16];
  assign in_kind      = kind_t'(s_axis_tuser[1:0]);
  assign in_first     = s_axis_tuser[2];
  assign in_last      = s_axis_tlast;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      valid_lo  <= RANGE_MIN_RESET;
      valid_hi  <= RANGE_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_THRESHOLD: threshold <= cfg_data;
        CFG_RANGE_MIN: valid_lo  <= cfg_data;
        CFG_RANGE_MAX: valid_hi  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign flush_held = held_valid && in_first;
  assign judge_held = held_valid && !in_first;

  assign rej = !held_is_first && (held_kind == KIND_FINITE) &&
               (held_range >= valid_lo) && (held_range <= valid_hi) &&
               differs(held_range, left_range, left_kind, threshold) &&
               differs(held_range, in_range, in_kind, threshold);

  always_comb begin
    if (flush_held) begin
      res_held = make_result(held_range, held_kind, held_intensity, 1'b0, 1'b1);
    end else if (rej) begin
      res_held = make_result('0, KIND_POS_INF, '0, 1'b1, 1'b0);
    end else begin
      res_held = make_result(held_range, held_kind, held_intensity, 1'b0, 1'b0);
    end
  end

  assign res_input = make_result(in_range, in_kind, in_intensity, 1'b0, 1'b1);
  assign din0      = held_valid ? res_held : res_input;

  assign push.first  = accept && (held_valid || in_last);
  assign push.second = accept && held_valid && in_last;

  sio_tap u_held (
    .clk      (clk),
    .load     (accept && !in_last),
    .range_in (in_range),
    .kind_in  (in_kind),
    .range_q  (held_range),
    .kind_q   (held_kind)
  );

  sio_tap u_prev (
    .clk      (clk),
    .load     (accept && judge_held),
    .range_in (held_range),
    .kind_in  (held_kind),
    .range_q  (left_range),
    .kind_q   (left_kind)
  );

  always_ff @(posedge clk) begin
    if (accept && !in_last) begin
      held_intensity <= in_intensity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      held_is_first <= 1'b0;
    end else if (accept) begin
      held_valid    <= !in_last;
      held_is_first <= !judge_held;
    end
  end

  assign pop = m_axis_tvalid && m_axis_tready;

  sio_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .din0         (din0),
    .din1         (res_input),
    .pop          (pop),
    .dout         (dout),
    .not_empty    (q_not_empty),
    .room_for_two (q_room),
    .level        (q_level)
  );

  assign s_axis_tready = q_room;
  assign m_axis_tvalid = q_not_empty;
  assign m_axis_tdata  = {dout.intensity, dout.range_mm};
  assign m_axis_tuser  = {dout.rejected, dout.kind};
  assign m_axis_tlast  = dout.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= ($clog2(OUTQ_DEPTH+1))'(OUTQ_DEPTH))
    else $error("result queue overfilled");

  a_last_clears_window: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !held_valid)
    else $error("window still holds a sample after the end of a scan");

  a_rejected_form: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |->
      (m_axis_tuser[1:0] == KIND_POS_INF) && (m_axis_tdata == '0) && !m_axis_tlast)
    else $error("rejected result is not a clean +inf sample");

  a_two_results_need_room: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second result pushed without a first");

endmodule
